// File: src/drbb_pkg.sv
// Shared types and constants for the depth region box builder.
package drbb_pkg;

    localparam int unsigned COEF_COUNT = 12;

    typedef enum logic [1:0] {
        OP_LOAD_COEF = 2'd0,
        OP_PIXEL     = 2'd1,
        OP_END       = 2'd2,
        OP_UNUSED    = 2'd3
    } opcode_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_FOCAL_RECIP_X   = 3'd0;
    localparam logic [2:0] REG_FOCAL_RECIP_Y   = 3'd1;
    localparam logic [2:0] REG_PRINCIPAL_COL   = 3'd2;
    localparam logic [2:0] REG_PRINCIPAL_ROW   = 3'd3;
    localparam logic [2:0] REG_POINT_THRESHOLD = 3'd4;

    // Datapath steps driven by the controller.
    typedef enum logic [3:0] {
        DP_IDLE   = 4'd0,
        DP_CAM_A  = 4'd1,   // du*d, dv*d
        DP_CAM_B  = 4'd2,   // times reciprocal, low and high parts
        DP_CAM_C  = 4'd3,   // combine parts and round
        DP_ROW    = 4'd4,   // one coefficient product of the transform
        DP_ROUND  = 4'd5,   // round, saturate one axis
        DP_FOLD   = 4'd6,   // fold point into box
        DP_EMIT   = 4'd7,   // build the result
        DP_LOAD   = 4'd8    // write a coefficient
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] axis;   // transform row
        logic [1:0] term;   // column within the row
    } dp_cmd_t;

    typedef struct packed {
        logic zero_depth;
    } dp_status_t;

endpackage

// File: src/drbb_if.sv
// Valid/ready channel interface carrying one payload.
interface drbb_if #(
    parameter type PAYLOAD_T = logic
) (
    input logic clk
);
    logic     valid;
    logic     ready;
    PAYLOAD_T data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/drbb_ctrl.sv
// Controller state machine sequencing the box builder datapath.
module drbb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           in_opcode,
    output logic                 out_valid,
    input  logic                 out_ready,
    output drbb_pkg::dp_cmd_t    cmd,
    input  drbb_pkg::dp_status_t status
);
    typedef enum logic [2:0] {
        S_IDLE, S_CAM_A, S_CAM_B, S_CAM_C, S_ROW, S_ROUND, S_FOLD, S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic [1:0] term_reg, term_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    // Only an end-of-region request has to wait for the result register to free up.
    assign in_ready  = (state_reg == S_IDLE)
                       && (!out_valid_reg || out_ready || (in_opcode != drbb_pkg::OP_END));
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Next state and command decode.
    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        term_next      = term_reg;
        out_valid_next = out_valid_reg;
        cmd.op         = drbb_pkg::DP_IDLE;
        cmd.axis       = axis_reg;
        cmd.term       = term_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (drbb_pkg::opcode_t'(in_opcode))
                        drbb_pkg::OP_LOAD_COEF: cmd.op = drbb_pkg::DP_LOAD;
                        drbb_pkg::OP_PIXEL:
                        begin
                            if (!status.zero_depth)
                            begin
                                cmd.op     = drbb_pkg::DP_CAM_A;
                                state_next = S_CAM_B;
                            end
                        end
                        drbb_pkg::OP_END:
                        begin
                            cmd.op         = drbb_pkg::DP_EMIT;
                            out_valid_next = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_CAM_B:
            begin
                cmd.op     = drbb_pkg::DP_CAM_B;
                state_next = S_CAM_C;
            end
            S_CAM_C:
            begin
                cmd.op     = drbb_pkg::DP_CAM_C;
                axis_next  = 2'd0;
                term_next  = 2'd0;
                state_next = S_ROW;
            end
            S_ROW:
            begin
                cmd.op = drbb_pkg::DP_ROW;
                if (term_reg == 2'd3)
                    state_next = S_ROUND;
                term_next = term_reg + 2'd1;
            end
            S_ROUND:
            begin
                cmd.op    = drbb_pkg::DP_ROUND;
                term_next = 2'd0;
                if (axis_reg == 2'd2)
                    state_next = S_FOLD;
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_ROW;
                end
            end
            S_FOLD:
            begin
                cmd.op     = drbb_pkg::DP_FOLD;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= 2'd0;
            term_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            term_reg      <= term_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// File: src/drbb_datapath.sv
// Back-projection, transform and box accumulation datapath.
module drbb_datapath #(
    parameter int MAX_REGION_PIXELS = 1048576,
    parameter int COORD_BITS        = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  drbb_pkg::dp_cmd_t    cmd,
    output drbb_pkg::dp_status_t status,
    input  logic [11:0]          pixel_col,
    input  logic [11:0]          pixel_row,
    input  logic [15:0]          depth_raw,
    input  logic [3:0]           coef_index,
    input  logic signed [31:0]   coef_value,
    input  logic [23:0]          focal_recip_x,
    input  logic [23:0]          focal_recip_y,
    input  logic [15:0]          principal_col,
    input  logic [15:0]          principal_row,
    input  logic [20:0]          point_threshold,
    output logic                 accepted,
    output logic [20:0]          point_count,
    output logic signed [23:0]   box_min_x,
    output logic signed [23:0]   box_min_y,
    output logic signed [23:0]   box_min_z,
    output logic signed [23:0]   box_max_x,
    output logic signed [23:0]   box_max_y,
    output logic signed [23:0]   box_max_z,
    output logic signed [23:0]   box_center_x,
    output logic signed [23:0]   box_center_y,
    output logic signed [23:0]   box_center_z
);
    localparam int CB = COORD_BITS;
    localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
    localparam logic [20:0] CNT_MAX = 21'(MAX_REGION_PIXELS);

    // Transform coefficients, identity after reset.
    logic signed [31:0] coef_reg [drbb_pkg::COEF_COUNT];

    // Camera-frame stage registers.
    logic [15:0]        depth_reg;
    logic               neg_x_reg, neg_y_reg;
    logic [32:0]        mag_dx_reg, mag_dy_reg;       // |du|*d (17b x 16b)
    logic [44:0]        lo_x_reg, lo_y_reg;           // mag * recip[11:0]
    logic [44:0]        hi_x_reg, hi_y_reg;           // mag * recip[23:12]
    logic signed [31:0] cam_reg [3];                  // x, y, z in mm
    logic signed [65:0] acc_reg;
    logic signed [CB-1:0] pt_reg [3];

    // Box accumulators.
    logic                 has_point_reg;
    logic [20:0]          count_reg;
    logic signed [CB-1:0] min_reg [3];
    logic signed [CB-1:0] max_reg [3];

    // Result register.
    logic                 acc_out_reg;
    logic [20:0]          cnt_out_reg;
    logic signed [CB-1:0] min_out_reg [3];
    logic signed [CB-1:0] max_out_reg [3];
    logic signed [CB-1:0] ctr_out_reg [3];

    logic signed [17:0] du, dv;
    logic [16:0]        adu, adv;
    logic [45:0]        sum_x, sum_y;
    logic [29:0]        rx, ry;
    logic signed [31:0] coef_sel;
    logic signed [31:0] cam_sel;
    logic signed [63:0] prod;
    logic [65:0]        mag_acc;
    logic [65:0]        rnd_mag;
    logic signed [66:0] rnd_val;
    logic signed [CB-1:0] sat_val;

    assign status.zero_depth = (depth_raw == 16'd0);

    assign du  = $signed({2'b0, pixel_col, 4'b0}) - $signed({2'b0, principal_col});
    assign dv  = $signed({2'b0, pixel_row, 4'b0}) - $signed({2'b0, principal_row});
    assign adu = du[17] ? 17'(-du) : du[16:0];
    assign adv = dv[17] ? 17'(-dv) : dv[16:0];

    // Combine partial products and round at bit 28.
    assign sum_x = {1'b0, hi_x_reg} + {1'b0, lo_x_reg >> 12};
    assign sum_y = {1'b0, hi_y_reg} + {1'b0, lo_y_reg >> 12};
    // Product = sum*2^12 + lo[11:0]; rounding adds 2^27 = 2^12*2^15.
    assign rx = 30'((sum_x + 46'(1 << 15)) >> 16);
    assign ry = 30'((sum_y + 46'(1 << 15)) >> 16);

    // One coefficient product per cycle.
    assign coef_sel = coef_reg[{cmd.axis, cmd.term}];
    assign cam_sel  = (cmd.term == 2'd3) ? 32'sd1 : cam_reg[cmd.term];
    assign prod     = coef_sel * cam_sel;

    // Round Q16.16 to mm, ties away from zero, then saturate.
    assign mag_acc = acc_reg[65] ? 66'(-acc_reg) : 66'(acc_reg);
    assign rnd_mag = (mag_acc + 66'(1 << 15)) >> 16;
    assign rnd_val = acc_reg[65] ? -$signed({1'b0, rnd_mag}) : $signed({1'b0, rnd_mag});
    always_comb
    begin
        if (rnd_val > 67'(CMAX))
            sat_val = CMAX;
        else if (rnd_val < 67'(CMIN))
            sat_val = CMIN;
        else
            sat_val = CB'(rnd_val);
    end

    // Coefficient store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < drbb_pkg::COEF_COUNT; i++)
                coef_reg[i] <= (i == 0 || i == 5 || i == 10) ? 32'sd65536 : 32'sd0;
        end
        else if (cmd.op == drbb_pkg::DP_LOAD && coef_index < 4'd12)
            coef_reg[coef_index] <= coef_value;
    end

    // Projection and transform pipeline registers.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            drbb_pkg::DP_CAM_A:
            begin
                depth_reg  <= depth_raw;
                neg_x_reg  <= du[17];
                neg_y_reg  <= dv[17];
                mag_dx_reg <= adu * depth_raw;
                mag_dy_reg <= adv * depth_raw;
            end
            drbb_pkg::DP_CAM_B:
            begin
                lo_x_reg <= mag_dx_reg * focal_recip_x[11:0];
                lo_y_reg <= mag_dy_reg * focal_recip_y[11:0];
                hi_x_reg <= mag_dx_reg * focal_recip_x[23:12];
                hi_y_reg <= mag_dy_reg * focal_recip_y[23:12];
            end
            drbb_pkg::DP_CAM_C:
            begin
                cam_reg[0] <= neg_x_reg ? -$signed({2'b0, rx}) : $signed({2'b0, rx});
                cam_reg[1] <= neg_y_reg ? -$signed({2'b0, ry}) : $signed({2'b0, ry});
                cam_reg[2] <= $signed({16'b0, depth_reg});
                acc_reg    <= '0;
            end
            drbb_pkg::DP_ROW:
                acc_reg <= acc_reg + 66'(prod);
            drbb_pkg::DP_ROUND:
            begin
                pt_reg[cmd.axis] <= sat_val;
                acc_reg          <= '0;
            end
            default: ;
        endcase
    end

    // Box accumulators and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_point_reg <= 1'b0;
            count_reg     <= '0;
            for (int i = 0; i < 3; i++)
            begin
                min_reg[i] <= '0;
                max_reg[i] <= '0;
            end
        end
        else if (cmd.op == drbb_pkg::DP_FOLD)
        begin
            has_point_reg <= 1'b1;
            if (count_reg < CNT_MAX)
                count_reg <= count_reg + 21'd1;
            for (int i = 0; i < 3; i++)
            begin
                if (!has_point_reg || pt_reg[i] < min_reg[i])
                    min_reg[i] <= pt_reg[i];
                if (!has_point_reg || pt_reg[i] > max_reg[i])
                    max_reg[i] <= pt_reg[i];
            end
        end
        else if (cmd.op == drbb_pkg::DP_EMIT)
        begin
            has_point_reg <= 1'b0;
            count_reg     <= '0;
            for (int i = 0; i < 3; i++)
            begin
                min_reg[i] <= '0;
                max_reg[i] <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == drbb_pkg::DP_EMIT)
        begin
            acc_out_reg <= (count_reg >= point_threshold) && (count_reg != 21'd0);
            cnt_out_reg <= count_reg;
            for (int i = 0; i < 3; i++)
            begin
                min_out_reg[i] <= min_reg[i];
                max_out_reg[i] <= max_reg[i];
                ctr_out_reg[i] <= CB'(($signed({min_reg[i][CB-1], min_reg[i]})
                                     + $signed({max_reg[i][CB-1], max_reg[i]})) >>> 1);
            end
        end
    end

    assign accepted     = acc_out_reg;
    assign point_count  = cnt_out_reg;
    assign box_min_x    = 24'(min_out_reg[0]);
    assign box_min_y    = 24'(min_out_reg[1]);
    assign box_min_z    = 24'(min_out_reg[2]);
    assign box_max_x    = 24'(max_out_reg[0]);
    assign box_max_y    = 24'(max_out_reg[1]);
    assign box_max_z    = 24'(max_out_reg[2]);
    assign box_center_x = 24'(ctr_out_reg[0]);
    assign box_center_y = 24'(ctr_out_reg[1]);
    assign box_center_z = 24'(ctr_out_reg[2]);
endmodule

// File: src/depth_roi_box_builder_top.sv
// Top level of the depth region box builder.
// Each depth pixel request runs the back-projection steps CAM_A, CAM_B and CAM_C,
// then 4 coefficient products for each of the three transform rows on one 32x32
// multiplier plus a round step per row, and a fold step. Load and end-of-region
// requests are handled in the idle state, where zero-depth pixels are dropped.
// A finished box is held in the output register until taken; pixels and loads are
// still taken while it waits, but the next end-of-region request waits until the box
// is taken, at the earliest in the same cycle.
module depth_roi_box_builder_top #(
    parameter int MAX_REGION_PIXELS = 1048576,
    parameter int COORD_BITS        = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [11:0] pixel_col,
    input  logic [11:0] pixel_row,
    input  logic [15:0] depth_raw,
    input  logic [3:0]  coef_index,
    input  logic signed [31:0] coef_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        accepted,
    output logic [20:0] point_count,
    output logic signed [23:0] box_min_x,
    output logic signed [23:0] box_min_y,
    output logic signed [23:0] box_min_z,
    output logic signed [23:0] box_max_x,
    output logic signed [23:0] box_max_y,
    output logic signed [23:0] box_max_z,
    output logic signed [23:0] box_center_x,
    output logic signed [23:0] box_center_y,
    output logic signed [23:0] box_center_z
);
    logic [23:0] focal_recip_x_reg, focal_recip_y_reg;
    logic [15:0] principal_col_reg, principal_row_reg;
    logic [20:0] point_threshold_reg;
    logic        cfg_write;
    logic [2:0]  cfg_sel;
    drbb_pkg::dp_cmd_t    cmd;
    drbb_pkg::dp_status_t status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = paddr[4:2];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_recip_x_reg   <= 24'd27962;
            focal_recip_y_reg   <= 24'd27962;
            principal_col_reg   <= 16'd5120;
            principal_row_reg   <= 16'd3840;
            point_threshold_reg <= 21'd50;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                drbb_pkg::REG_FOCAL_RECIP_X:   focal_recip_x_reg   <= pwdata[23:0];
                drbb_pkg::REG_FOCAL_RECIP_Y:   focal_recip_y_reg   <= pwdata[23:0];
                drbb_pkg::REG_PRINCIPAL_COL:   principal_col_reg   <= pwdata[15:0];
                drbb_pkg::REG_PRINCIPAL_ROW:   principal_row_reg   <= pwdata[15:0];
                drbb_pkg::REG_POINT_THRESHOLD: point_threshold_reg <= pwdata[20:0];
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        case (cfg_sel)
            drbb_pkg::REG_FOCAL_RECIP_X:   prdata = {8'b0, focal_recip_x_reg};
            drbb_pkg::REG_FOCAL_RECIP_Y:   prdata = {8'b0, focal_recip_y_reg};
            drbb_pkg::REG_PRINCIPAL_COL:   prdata = {16'b0, principal_col_reg};
            drbb_pkg::REG_PRINCIPAL_ROW:   prdata = {16'b0, principal_row_reg};
            drbb_pkg::REG_POINT_THRESHOLD: prdata = {11'b0, point_threshold_reg};
            default:                       prdata = 32'b0;
        endcase
    end

    drbb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_opcode (opcode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    drbb_datapath #(
        .MAX_REGION_PIXELS (MAX_REGION_PIXELS),
        .COORD_BITS        (COORD_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .pixel_col       (pixel_col),
        .pixel_row       (pixel_row),
        .depth_raw       (depth_raw),
        .coef_index      (coef_index),
        .coef_value      (coef_value),
        .focal_recip_x   (focal_recip_x_reg),
        .focal_recip_y   (focal_recip_y_reg),
        .principal_col   (principal_col_reg),
        .principal_row   (principal_row_reg),
        .point_threshold (point_threshold_reg),
        .accepted        (accepted),
        .point_count     (point_count),
        .box_min_x       (box_min_x),
        .box_min_y       (box_min_y),
        .box_min_z       (box_min_z),
        .box_max_x       (box_max_x),
        .box_max_y       (box_max_y),
        .box_max_z       (box_max_z),
        .box_center_x    (box_center_x),
        .box_center_y    (box_center_y),
        .box_center_z    (box_center_z)
    );

    // No end-of-region request is taken while a result waits and is not being taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !(in_ready && opcode == drbb_pkg::OP_END))
        else $error("end of region taken while result pending");
    // An end-of-region request raises the result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && opcode == drbb_pkg::OP_END) |=> out_valid)
        else $error("end of region gave no result");
    // An accepted box never has a zero count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && accepted) |-> (point_count != 21'd0))
        else $error("accepted empty region");
endmodule

// File: dv/depth_roi_box_builder_top_test.sv
// Testbench for the depth region box builder: directed and random regions checked against a box predictor.
`timescale 1ns / 100ps

module depth_roi_box_builder_top_test;

    typedef struct packed {
        drbb_pkg::opcode_t  opcode;
        logic [11:0]        pixel_col;
        logic [11:0]        pixel_row;
        logic [15:0]        depth_raw;
        logic [3:0]         coef_index;
        logic signed [31:0] coef_value;
    } pixel_req_t;

    typedef struct packed {
        logic               accepted;
        logic [20:0]        point_count;
        logic signed [23:0] min_x;
        logic signed [23:0] min_y;
        logic signed [23:0] min_z;
        logic signed [23:0] max_x;
        logic signed [23:0] max_y;
        logic signed [23:0] max_z;
        logic signed [23:0] center_x;
        logic signed [23:0] center_y;
        logic signed [23:0] center_z;
    } box_res_t;

    localparam longint COUNT_CAP = 1048576;
    localparam longint COORD_HI  = 8388607;
    localparam longint COORD_LO  = -8388608;
    localparam int     DRAIN_CYCLES = 40;

    // Predicts region boxes and holds the boxes still to come.
    class box_scoreboard;
        longint unsigned recip_x, recip_y, center_col, center_row, min_pts;
        longint coefs[12];
        longint corner_lo[3];
        longint corner_hi[3];
        longint unsigned points;
        bit     seen_point;
        box_res_t pending_boxes[$];
        int     errors;

        function new();
            recip_x = 27962;
            recip_y = 27962;
            center_col = 5120;
            center_row = 3840;
            min_pts = 50;
            foreach (coefs[i]) coefs[i] = 0;
            coefs[0] = 65536;
            coefs[5] = 65536;
            coefs[10] = 65536;
            errors = 0;
            clear_box();
        endfunction

        function void clear_box();
            points = 0;
            seen_point = 0;
            for (int i = 0; i < 3; i++)
            begin
                corner_lo[i] = 0;
                corner_hi[i] = 0;
            end
        endfunction

        function void set_reg(int idx, longint unsigned value);
            case (idx)
                drbb_pkg::REG_FOCAL_RECIP_X:   recip_x = value & 24'hFFFFFF;
                drbb_pkg::REG_FOCAL_RECIP_Y:   recip_y = value & 24'hFFFFFF;
                drbb_pkg::REG_PRINCIPAL_COL:   center_col = value & 16'hFFFF;
                drbb_pkg::REG_PRINCIPAL_ROW:   center_row = value & 16'hFFFF;
                drbb_pkg::REG_POINT_THRESHOLD: min_pts = value & 21'h1FFFFF;
                default: ;
            endcase
        endfunction

        // Nearest millimetre, ties away from zero.
        function longint round_mm(longint v, int n);
            longint half;
            half = longint'(1) << (n - 1);
            if (v >= 0)
                return (v + half) >>> n;
            return -((-v + half) >>> n);
        endfunction

        function longint clamp_coord(longint v);
            if (v > COORD_HI)
                return COORD_HI;
            if (v < COORD_LO)
                return COORD_LO;
            return v;
        endfunction

        function longint lateral_mm(longint pix, longint principal, longint recip, longint d);
            longint du, mag, r;
            du = (pix << 4) - principal;
            mag = (du < 0 ? -du : du) * d * recip;
            r = (mag + (longint'(1) << 27)) >>> 28;
            return du < 0 ? -r : r;
        endfunction

        function longint half_floor(longint s);
            if (s >= 0)
                return s / 2;
            return -((-s + 1) / 2);
        endfunction

        function void note_request(pixel_req_t r);
            longint cam[3];
            longint pt[3];
            longint acc;
            box_res_t b;
            case (r.opcode)
                drbb_pkg::OP_LOAD_COEF:
                begin
                    if (r.coef_index < drbb_pkg::COEF_COUNT)
                        coefs[r.coef_index] = longint'(r.coef_value);
                end
                drbb_pkg::OP_PIXEL:
                begin
                    if (r.depth_raw != 0)
                    begin
                        cam[0] = lateral_mm(r.pixel_col, center_col, recip_x, r.depth_raw);
                        cam[1] = lateral_mm(r.pixel_row, center_row, recip_y, r.depth_raw);
                        cam[2] = r.depth_raw;
                        for (int i = 0; i < 3; i++)
                        begin
                            acc = coefs[4*i] * cam[0] + coefs[4*i+1] * cam[1]
                                + coefs[4*i+2] * cam[2] + coefs[4*i+3];
                            pt[i] = clamp_coord(round_mm(acc, 16));
                        end
                        for (int i = 0; i < 3; i++)
                        begin
                            if (!seen_point || pt[i] < corner_lo[i]) corner_lo[i] = pt[i];
                            if (!seen_point || pt[i] > corner_hi[i]) corner_hi[i] = pt[i];
                        end
                        seen_point = 1;
                        if (points < COUNT_CAP)
                            points++;
                    end
                end
                drbb_pkg::OP_END:
                begin
                    b.accepted = (points >= min_pts) && (points != 0);
                    b.point_count = 21'(points);
                    b.min_x = 24'(corner_lo[0]);
                    b.min_y = 24'(corner_lo[1]);
                    b.min_z = 24'(corner_lo[2]);
                    b.max_x = 24'(corner_hi[0]);
                    b.max_y = 24'(corner_hi[1]);
                    b.max_z = 24'(corner_hi[2]);
                    b.center_x = 24'(half_floor(corner_lo[0] + corner_hi[0]));
                    b.center_y = 24'(half_floor(corner_lo[1] + corner_hi[1]));
                    b.center_z = 24'(half_floor(corner_lo[2] + corner_hi[2]));
                    pending_boxes.insert(pending_boxes.size(), b);
                    clear_box();
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_box(box_res_t got);
            box_res_t want;
            if (pending_boxes.size() == 0)
            begin
                $error("box result with none expected");
                errors++;
                return;
            end
            want = pending_boxes.pop_front();
            compare_field("accepted", want.accepted, got.accepted);
            compare_field("point_count", want.point_count, got.point_count);
            compare_field("box_min_x", want.min_x, got.min_x);
            compare_field("box_min_y", want.min_y, got.min_y);
            compare_field("box_min_z", want.min_z, got.min_z);
            compare_field("box_max_x", want.max_x, got.max_x);
            compare_field("box_max_y", want.max_y, got.max_y);
            compare_field("box_max_z", want.max_z, got.max_z);
            compare_field("box_center_x", want.center_x, got.center_x);
            compare_field("box_center_y", want.center_y, got.center_y);
            compare_field("box_center_z", want.center_z, got.center_z);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    drbb_if #(.PAYLOAD_T(pixel_req_t)) req_ch (clk);
    drbb_if #(.PAYLOAD_T(box_res_t))   box_ch (clk);

    box_scoreboard sb;
    bit idle_on;
    int hold_off;

    depth_roi_box_builder_top DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(req_ch.valid), .in_ready(req_ch.ready),
        .opcode(req_ch.data.opcode), .pixel_col(req_ch.data.pixel_col),
        .pixel_row(req_ch.data.pixel_row), .depth_raw(req_ch.data.depth_raw),
        .coef_index(req_ch.data.coef_index), .coef_value(req_ch.data.coef_value),
        .out_valid(box_ch.valid), .out_ready(box_ch.ready),
        .accepted(box_ch.data.accepted), .point_count(box_ch.data.point_count),
        .box_min_x(box_ch.data.min_x), .box_min_y(box_ch.data.min_y),
        .box_min_z(box_ch.data.min_z), .box_max_x(box_ch.data.max_x),
        .box_max_y(box_ch.data.max_y), .box_max_z(box_ch.data.max_z),
        .box_center_x(box_ch.data.center_x), .box_center_y(box_ch.data.center_y),
        .box_center_z(box_ch.data.center_z)
    );

    // Clock.
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

    // Result side: random stalls, a long hold-off on request, checks each box.
    initial
    begin
        box_ch.ready = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && box_ch.valid && box_ch.ready)
                sb.check_box(box_ch.data);
            if (hold_off > 0)
            begin
                hold_off--;
                box_ch.ready <= 0;
            end
            else
                box_ch.ready <= !idle_on || ($urandom_range(99) >= 33);
        end
    end

    // One register write with setup and access phases; the bus then goes idle before the task returns.
    task automatic write_reg(int idx, logic [31:0] value);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= 5'(4 * idx);
        pwdata <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        sb.set_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic send_request(pixel_req_t r);
        if (idle_on && $urandom_range(99) < 33)
        begin
            req_ch.valid <= 0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_ch.valid <= 1;
        req_ch.data <= r;
        do @(posedge clk); while (!req_ch.ready);
        sb.note_request(r);
    endtask

    function automatic pixel_req_t make_req(drbb_pkg::opcode_t op, int col, int row,
                                            int depth, int idx, logic [31:0] value);
        pixel_req_t r;
        r.opcode = op;
        r.pixel_col = 12'(col);
        r.pixel_row = 12'(row);
        r.depth_raw = 16'(depth);
        r.coef_index = 4'(idx);
        r.coef_value = value;
        return r;
    endfunction

    task automatic send_pixel(int col, int row, int depth);
        send_request(make_req(drbb_pkg::OP_PIXEL, col, row, depth, $urandom, $urandom));
    endtask

    task automatic send_coef(int idx, logic [31:0] value);
        send_request(make_req(drbb_pkg::OP_LOAD_COEF, $urandom, $urandom, $urandom,
                              idx, value));
    endtask

    task automatic send_end();
        send_request(make_req(drbb_pkg::OP_END, $urandom, $urandom, $urandom,
                              $urandom, $urandom));
    endtask

    task automatic load_identity();
        for (int i = 0; i < drbb_pkg::COEF_COUNT; i++)
            send_coef(i, (i % 5 == 0) ? 32'sd65536 : 32'sd0);
    endtask

    // Waits for every box, then lets the block settle before registers change.
    task automatic drain();
        req_ch.valid <= 0;
        while (sb.pending_boxes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random regions of mostly well-formed pixels with some noise.
    task automatic random_phase(int n_items);
        int sent;
        int len;
        int pick;
        logic [31:0] value;
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 40);
            for (int k = 0; k < len; k++)
            begin
                pick = $urandom_range(99);
                if (pick < 4)
                begin
                    value = $urandom_range(1) ? $urandom
                                              : 32'($signed($urandom_range(262144)) - 131072);
                    send_coef($urandom_range(15), value);
                end
                else if (pick < 7)
                    send_request(make_req(drbb_pkg::OP_UNUSED, $urandom, $urandom, $urandom,
                                          $urandom, $urandom));
                else if (pick < 17)
                    send_pixel($urandom, $urandom, 0);
                else
                    send_pixel($urandom_range(4095), $urandom_range(4095),
                               $urandom_range(1) ? $urandom_range(65535)
                                                 : $urandom_range(300, 5000));
                sent++;
            end
            send_end();
            sent++;
        end
    endtask

    // Register settings for one random phase; extremes come up now and then.
    task automatic random_regs();
        write_reg(drbb_pkg::REG_FOCAL_RECIP_X,
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(80000));
        write_reg(drbb_pkg::REG_FOCAL_RECIP_Y,
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(80000));
        write_reg(drbb_pkg::REG_PRINCIPAL_COL, $urandom_range(65535));
        write_reg(drbb_pkg::REG_PRINCIPAL_ROW, $urandom_range(65535));
        write_reg(drbb_pkg::REG_POINT_THRESHOLD, $urandom_range(40));
    endtask

    // Main sequence.
    initial
    begin
        sb = new();
        idle_on = 1;
        hold_off = 0;
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        req_ch.valid = 0;
        req_ch.data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: reset settings, empty region, short region below the threshold.
        send_end();
        send_pixel(0, 0, 1);
        send_pixel(4095, 4095, 65535);
        send_pixel(320, 240, 0);
        send_request(make_req(drbb_pkg::OP_UNUSED, 4095, 4095, 65535, 15, 32'hFFFFFFFF));
        send_end();
        // Extreme coefficients saturate the x and y axes and give z a large offset; a slot above the table is ignored.
        send_coef(0, 32'h7FFFFFFF);
        send_coef(5, 32'h80000000);
        send_coef(11, 32'h7FFFFFFF);
        send_coef(15, 32'h00000000);
        send_pixel(4095, 0, 65535);
        send_pixel(0, 4095, 65535);
        send_end();
        load_identity();
        drain();

        // Register extremes, all low then all high.
        write_reg(drbb_pkg::REG_FOCAL_RECIP_X, 0);
        write_reg(drbb_pkg::REG_FOCAL_RECIP_Y, 0);
        write_reg(drbb_pkg::REG_PRINCIPAL_COL, 0);
        write_reg(drbb_pkg::REG_PRINCIPAL_ROW, 0);
        write_reg(drbb_pkg::REG_POINT_THRESHOLD, 0);
        send_end();
        send_pixel(4095, 4095, 65535);
        send_end();
        drain();
        write_reg(drbb_pkg::REG_FOCAL_RECIP_X, 32'hFFFFFF);
        write_reg(drbb_pkg::REG_FOCAL_RECIP_Y, 32'hFFFFFF);
        write_reg(drbb_pkg::REG_PRINCIPAL_COL, 32'hFFFF);
        write_reg(drbb_pkg::REG_PRINCIPAL_ROW, 32'hFFFF);
        write_reg(drbb_pkg::REG_POINT_THRESHOLD, 32'h100000);
        send_pixel(0, 0, 65535);
        send_pixel(4095, 4095, 65535);
        send_end();
        drain();

        // Random phases; one without idling and one with a long result stall that
        // spans several regions so the block stalls its input.
        for (int p = 0; p < 7; p++)
        begin
            random_regs();
            idle_on = (p != 2);
            if (p == 4)
                hold_off = 4000;
            random_phase(210);
            drain();
        end
        idle_on = 1;

        if (sb.errors == 0 && sb.pending_boxes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
